// ===== hdl/nfli_pkg.sv =====
package nfli_pkg;

   localparam int LINE_LENGTH = 128;
   localparam int POS_W       = $clog2(LINE_LENGTH);
   localparam int PREFIX_LEN  = 6;
   localparam int MODE_POS    = 9;

   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_MODE_3D = 8'h33;

   localparam logic [10:0] SILENCE_MAX     = 11'h7FF;
   localparam logic [10:0] TIMEOUT_RESET   = 11'd1800;
   localparam logic [4:0]  BLINK_DIV_RESET = 5'd30;
   localparam logic [2:0]  SLOWDOWN_RESET  = 3'd5;

   localparam int CSR_DATA_W = 11;

   typedef enum logic [1:0] {
      CSR_TIMEOUT  = 2'd0,
      CSR_BLINK    = 2'd1,
      CSR_SLOWDOWN = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      FIX_LOCK   = 2'd0,
      FIX_NOLOCK = 2'd1,
      FIX_NODATA = 2'd2
   } fix_type;

   typedef enum logic [1:0] {
      LED_NONE  = 2'd0,
      LED_GREEN = 2'd1,
      LED_RED   = 2'd2
   } led_type;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0] fix_status;
      logic [1:0] led_color;
      logic       led_lit;
      logic       good_signal;
   } rsp_item_type;

   // End of a line whose prefix matched
   typedef struct packed {
      logic done;
      logic lock;
   } line_event_type;

   function automatic logic [7:0] gsa_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h24; // '$'
         3'd1:    c = 8'h47; // 'G'
         3'd2:    c = 8'h50; // 'P'
         3'd3:    c = 8'h47; // 'G'
         3'd4:    c = 8'h53; // 'S'
         3'd5:    c = 8'h41; // 'A'
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/nfli_line.sv =====
module nfli_line
   import nfli_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           byte_en,
   input  logic [7:0]     rx_byte,
   output line_event_type line_event
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             prefix_ff, prefix_in;
   logic [7:0]       mode_ff, mode_in;

   logic [POS_W:0]   pos_plus;
   logic             line_end;
   logic             prefix_ok;
   logic [7:0]       mode_next;

   always_comb begin
      pos_plus  = {1'b0, pos_ff} + (POS_W+1)'(1);
      line_end  = (pos_plus >= (POS_W+1)'(LINE_LENGTH)) ||
                  (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);
      prefix_ok = prefix_ff &&
                  !((pos_ff < POS_W'(PREFIX_LEN)) && (rx_byte != gsa_char(pos_ff[2:0])));
      mode_next = (pos_ff == POS_W'(MODE_POS)) ? rx_byte : mode_ff;

      line_event.done = byte_en && line_end && prefix_ok;
      line_event.lock = (pos_plus > (POS_W+1)'(MODE_POS)) && (mode_next == CHAR_MODE_3D);

      pos_in    = pos_ff;
      prefix_in = prefix_ff;
      mode_in   = mode_ff;
      if (byte_en) begin
         if (line_end) begin
            // restart for the next line
            pos_in    = '0;
            prefix_in = 1'b1;
            mode_in   = '0;
         end else begin
            pos_in    = pos_plus[POS_W-1:0];
            prefix_in = prefix_ok;
            mode_in   = mode_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         prefix_ff <= 1'b1;
         mode_ff   <= '0;
      end else begin
         pos_ff    <= pos_in;
         prefix_ff <= prefix_in;
         mode_ff   <= mode_in;
      end
   end

   a_line_restart: assert property (@(posedge clock) disable iff (reset)
      (byte_en && line_event.done) |=> (pos_ff == '0 && prefix_ff && mode_ff == '0))
      else $error("line state not restarted after matching line end");

endmodule

// ===== hdl/nfli_status.sv =====
module nfli_status
   import nfli_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           tick_en,
   input  line_event_type line_event,
   input  logic [10:0]    timeout_ticks,
   input  logic [4:0]     blink_divider,
   input  logic [2:0]     nodata_slowdown,
   output rsp_item_type   status
);

   fix_type     fix_ff, fix_in;
   logic [10:0] silence_ff, silence_in;
   logic [4:0]  div_ff, div_in;
   logic        blink_ff, blink_in;
   logic [2:0]  slow_ff, slow_in;
   led_type     color_ff, color_in;
   logic        good_ff, good_in;

   logic [5:0]  div_plus;
   logic [3:0]  slow_plus;
   logic [10:0] silence_plus;

   always_comb begin
      fix_in     = fix_ff;
      silence_in = silence_ff;
      div_in     = div_ff;
      blink_in   = blink_ff;
      slow_in    = slow_ff;
      color_in   = color_ff;
      good_in    = good_ff;

      silence_plus = silence_ff + 11'd1;
      div_plus     = {1'b0, div_ff} + 6'd1;
      slow_plus    = {1'b0, slow_ff} + 4'd1;

      if (line_event.done) begin
         silence_in = '0;
         fix_in     = line_event.lock ? FIX_LOCK : FIX_NOLOCK;
         good_in    = line_event.lock;
      end

      if (tick_en) begin
         // saturate; force no-data only on the tick that hits the timeout
         if (silence_ff != SILENCE_MAX) begin
            silence_in = silence_plus;
            if (silence_plus == timeout_ticks) begin
               fix_in  = FIX_NODATA;
               good_in = 1'b0;
            end
         end
         div_in = div_plus[4:0];
         if (div_plus >= {1'b0, blink_divider}) begin
            div_in = '0;
            case (fix_in)
               FIX_LOCK: begin
                  color_in = LED_GREEN;
                  blink_in = !blink_ff;
               end
               FIX_NOLOCK: begin
                  color_in = LED_RED;
                  blink_in = !blink_ff;
               end
               default: begin
                  color_in = LED_RED;
                  slow_in  = slow_plus[2:0];
                  if (slow_plus >= {1'b0, nodata_slowdown}) begin
                     blink_in = !blink_ff;
                     slow_in  = '0;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fix_ff     <= FIX_NODATA;
         silence_ff <= '0;
         div_ff     <= '0;
         blink_ff   <= 1'b0;
         slow_ff    <= '0;
         color_ff   <= LED_NONE;
         good_ff    <= 1'b0;
      end else begin
         fix_ff     <= fix_in;
         silence_ff <= silence_in;
         div_ff     <= div_in;
         blink_ff   <= blink_in;
         slow_ff    <= slow_in;
         color_ff   <= color_in;
         good_ff    <= good_in;
      end
   end

   always_comb begin
      status.fix_status  = fix_ff;
      status.led_color   = color_ff;
      status.led_lit     = blink_ff && (color_ff != LED_NONE);
      status.good_signal = good_ff;
   end

   a_good_means_lock: assert property (@(posedge clock) disable iff (reset)
      good_ff |-> (fix_ff == FIX_LOCK))
      else $error("good signal outside lock state");

   a_timeout_forces_nodata: assert property (@(posedge clock) disable iff (reset)
      (tick_en && !line_event.done && silence_ff != SILENCE_MAX &&
       silence_plus == timeout_ticks) |=> (fix_ff == FIX_NODATA && !good_ff))
      else $error("timeout did not force no-data state");

endmodule

// ===== hdl/nmea_fix_lock_indicator_top.sv =====
// Watches GPS serial bytes (operation 0) and timer ticks (operation 1) and
// reports fix status and the LED drive. Each accepted item returns exactly one
// result showing the state after that item. An item is taken into an input
// register and then processed into the state registers, which also hold the
// result until it is taken, so the block sustains one item per cycle as long
// as results are taken; rsp_valid is registered with the state. Zero bytes
// are ignored but still return a result. Registers: index 0 timeout_ticks,
// 1 blink_divider, 2 nodata_slowdown; write them only while no item is in
// flight.
module nmea_fix_lock_indicator_top
   import nfli_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_item_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_item_type          rsp_data,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic           in_valid_ff, in_valid_in;
   req_item_type   in_item_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [10:0]    timeout_ff;
   logic [4:0]     blink_div_ff;
   logic [2:0]     slowdown_ff;

   logic           advance;
   logic           byte_en;
   logic           tick_en;
   line_event_type line_event;

   always_comb begin
      advance      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready    = !in_valid_ff || advance;
      in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
      byte_en      = advance && (in_item_ff.operation == OP_BYTE) &&
                     (in_item_ff.rx_byte != 8'h00);
      tick_en      = advance && (in_item_ff.operation == OP_TICK);
      rsp_valid    = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         blink_div_ff <= BLINK_DIV_RESET;
         slowdown_ff  <= SLOWDOWN_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_TIMEOUT:  timeout_ff   <= csr_wdata[10:0];
            CSR_BLINK:    blink_div_ff <= csr_wdata[4:0];
            CSR_SLOWDOWN: slowdown_ff  <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   nfli_line u_line (
      .clock      (clock),
      .reset      (reset),
      .byte_en    (byte_en),
      .rx_byte    (in_item_ff.rx_byte),
      .line_event (line_event)
   );

   nfli_status u_status (
      .clock           (clock),
      .reset           (reset),
      .tick_en         (tick_en),
      .line_event      (line_event),
      .timeout_ticks   (timeout_ff),
      .blink_divider   (blink_div_ff),
      .nodata_slowdown (slowdown_ff),
      .status          (rsp_data)
   );

   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed item produced no result");

endmodule
